### sv/ufhu_pkg.sv
// Shared types, character codes and UTF-8 class functions for the header unescaper.
// No dependencies.
package ufhu_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QLVL_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_C  = 8'h63;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } ufhu_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } ufhu_out_t;

    // An accepted input word that yields output expands to 1..4 result words.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            data;   // 0: bare end marker
        logic            last;
    } ufhu_entry_t;

    function automatic logic is_cont(input logic [7:0] b);
        return b inside {[8'h80:8'hBF]};
    endfunction

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        if (b inside {[8'hC2:8'hDF]}) return 3'd2;
        if (b inside {[8'hE0:8'hEF]}) return 3'd3;
        if (b inside {[8'hF0:8'hF4]}) return 3'd4;
        return 3'd0;
    endfunction

    function automatic logic second_fits(input logic [7:0] lead, input logic [7:0] b);
        case (lead)
            8'hE0:   return b inside {[8'hA0:8'hBF]};
            8'hED:   return b inside {[8'h80:8'h9F]};
            8'hF0:   return b inside {[8'h90:8'hBF]};
            8'hF4:   return b inside {[8'h80:8'h8F]};
            default: return is_cont(b);
        endcase
    endfunction

    function automatic logic passes_alone(input logic [7:0] b);
        return (b inside {CH_TAB, CH_LF, CH_CR}) || (b inside {[8'h20:8'h7E]});
    endfunction

endpackage

### sv/ufhu_front.sv
// Front end: escape and UTF-8 state, turns one input word into at most one queue entry.
// Depends on ufhu_pkg.
module ufhu_front
    import ufhu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        take,
    input  ufhu_in_t    in_data,
    output logic        push,
    output ufhu_entry_t entry
);

    logic [2:0][7:0] pb_reg, pb_next;
    logic [1:0]      pc_reg, pc_next;
    logic            esc_reg, esc_next;

    always_comb begin
        logic [7:0] b;
        logic [7:0] lead;
        logic [2:0] n;
        logic       done;
        b        = in_data.in_byte;
        lead     = pb_reg[0];
        n        = 3'd0;
        done     = 1'b0;
        pb_next  = pb_reg;
        pc_next  = pc_reg;
        esc_next = esc_reg;
        entry    = '0;
        entry.data = 1'b1;

        // held multi-byte sequence; escape is never held at the same time
        if (pc_reg != 2'd0) begin
            if ((pc_reg == 2'd1) ? second_fits(lead, b) : is_cont(b)) begin
                done = 1'b1;
                if ({1'b0, pc_reg} + 3'd1 >= seq_len(lead)) begin
                    for (int k = 0; k < 3; k++) begin
                        if (k < int'(pc_reg)) entry.bytes[2'(k)] = pb_reg[2'(k)];
                    end
                    entry.bytes[pc_reg] = b;
                    n       = {1'b0, pc_reg} + 3'd1;
                    pc_next = 2'd0;
                end else if (pc_reg != 2'd3) begin
                    pb_next[pc_reg] = b;
                    pc_next = pc_reg + 2'd1;
                end else begin
                    pc_next = 2'd0;
                end
            end else begin
                pc_next = 2'd0;
            end
        end

        if (!done && esc_reg) begin
            esc_next = 1'b0;
            done     = 1'b1;
            case (b)
                CH_LOW_R:  entry.bytes[0] = CH_CR;
                CH_LOW_N:  entry.bytes[0] = CH_LF;
                CH_LOW_C:  entry.bytes[0] = CH_COLON;
                CH_BSLASH: entry.bytes[0] = CH_BSLASH;
                default: begin
                    entry.bytes[0] = CH_BSLASH;
                    done = 1'b0;
                end
            endcase
            n = 3'd1;
        end

        if (!done) begin
            if (b == CH_BSLASH) begin
                esc_next = 1'b1;
            end else if (passes_alone(b)) begin
                entry.bytes[n[1:0]] = b;
                n = n + 3'd1;
            end else if (seq_len(b) != 3'd0) begin
                pb_next[0] = b;
                pc_next    = 2'd1;
            end
        end

        if (in_data.in_last) begin
            if (esc_next) begin
                entry.bytes[n[1:0]] = CH_BSLASH;
                n = n + 3'd1;
            end
            esc_next = 1'b0;
            pc_next  = 2'd0;
            if (n == 3'd0) begin
                entry.data = 1'b0;
                n = 3'd1;
            end
        end

        entry.cnt  = n;
        entry.last = in_data.in_last;
        push       = take && (n != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= 2'd0;
            esc_reg <= 1'b0;
        end else if (take) begin
            pc_reg  <= pc_next;
            esc_reg <= esc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pb_reg <= pb_next;
        end
    end

endmodule

### sv/ufhu_queue.sv
// Short entry queue between front and back end.
// Depends on ufhu_pkg.
module ufhu_queue
    import ufhu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ufhu_entry_t       wr_entry,
    input  logic              pop,
    output ufhu_entry_t       head,
    output logic              head_valid,
    output logic              full,
    output logic [QLVL_W-1:0] level
);

    ufhu_entry_t       mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_W-1:0] lvl_reg, lvl_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (lvl_reg != '0);
    assign full       = (lvl_reg == QLVL_W'(QDEPTH));
    assign level      = lvl_reg;

    always_comb begin
        lvl_next = lvl_reg;
        if (push && !pop) lvl_next = lvl_reg + QLVL_W'(1);
        if (pop && !push) lvl_next = lvl_reg - QLVL_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            lvl_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            lvl_reg <= lvl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

### sv/ufhu_back.sv
// Back end: walks the head entry one byte per word into the output register.
// Depends on ufhu_pkg.
module ufhu_back
    import ufhu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ufhu_entry_t head,
    input  logic        head_valid,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output ufhu_out_t   m_data
);

    logic [1:0] idx_reg, idx_next;
    logic       vld_reg, vld_next;
    ufhu_out_t  dat_reg, dat_next;
    logic       load, at_end;

    assign load   = !vld_reg || m_ready;
    assign at_end = ({1'b0, idx_reg} + 3'd1 == head.cnt);

    always_comb begin
        idx_next = idx_reg;
        vld_next = vld_reg;
        dat_next = dat_reg;
        pop      = 1'b0;
        if (load) begin
            vld_next = head_valid;
            if (head_valid) begin
                dat_next.out_byte  = head.data ? head.bytes[idx_reg] : 8'h00;
                dat_next.out_valid = head.data;
                dat_next.out_last  = head.last && at_end;
                pop      = at_end;
                idx_next = at_end ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
            vld_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        dat_reg <= dat_next;
    end

    assign m_valid = vld_reg;
    assign m_data  = dat_reg;

endmodule

### sv/utf8_filtering_header_unescaper.sv
// Header string unescaper with UTF-8 filtering: one escaped byte per input word.
// Path: an accepted word's results are written to the queue, then loaded into the output register.
// Throughput: one input word per cycle while the 4-entry queue has room; the output
// side sends one word per cycle while m_ready is high, k transfers for a word yielding k.
// Reset: aresetn synchronous, active low; clears escape/sequence state, queue and output.
// Depends on ufhu_pkg, ufhu_front, ufhu_queue, ufhu_back.
module utf8_filtering_header_unescaper
    import ufhu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ufhu_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ufhu_out_t m_data
);

    // front -> queue
    logic        take;
    logic        q_push;
    ufhu_entry_t q_wr;

    // queue -> back
    ufhu_entry_t       q_head;
    logic              q_head_valid;
    logic              q_pop;
    logic              q_full;
    logic [QLVL_W-1:0] q_level;

    // The front end never waits on the output: only a full queue stalls it.
    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    ufhu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .in_data (s_data),
        .push    (q_push),
        .entry   (q_wr)
    );

    ufhu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .wr_entry   (q_wr),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid),
        .full       (q_full),
        .level      (q_level)
    );

    // Output register doubles as the skid stage toward the result side.
    ufhu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // Queue never pops empty.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (q_level != '0))
        else $error("queue popped while empty");

    // Queue occupancy stays within depth.
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= QLVL_W'(QDEPTH))
        else $error("queue level overflow");

    // A bare word is only ever an end marker with a zero byte.
    a_bare_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.out_valid) |-> (m_data.out_last && m_data.out_byte == 8'h00))
        else $error("bare word without end flag");

    // Queued entries always carry at least one word.
    a_entry_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_wr.cnt != 3'd0 && q_wr.cnt <= 3'd4))
        else $error("bad entry word count");

endmodule

### tb/sv/utf8_filtering_header_unescaper_tb.sv
// Self-checking testbench for utf8_filtering_header_unescaper: escape decoding and UTF-8
// filtering are predicted word by word and compared against the result channel.
// Depends on ufhu_pkg and the unescaper RTL.
module utf8_filtering_header_unescaper_tb;
    import ufhu_pkg::*;

    // Predicts the decoded words for every accepted input word and checks results in order.
    class unescape_scoreboard;
        logic [7:0]  seq_buf[3];   // held bytes of an unfinished UTF-8 sequence
        int unsigned seq_held;
        bit          bslash_held;
        ufhu_out_t   decoded_q[$];
        int unsigned errors;

        function new();
            seq_held    = 0;
            bslash_held = 1'b0;
            errors      = 0;
        endfunction

        // Total length of a multi-byte sequence started by b, 0 for anything else.
        function int unsigned lead_len(logic [7:0] b);
            if (b >= 8'hF5 || b < 8'hC2) return 0;
            if (b >= 8'hF0) return 4;
            if (b >= 8'hE0) return 3;
            return 2;
        endfunction

        // Second byte window: tighter for leads that could form overlongs, surrogates
        // or code points past U+10FFFF.
        function bit second_ok(logic [7:0] lead, logic [7:0] b);
            logic [7:0] lo;
            logic [7:0] hi;
            lo = 8'h80;
            hi = 8'hBF;
            if (lead == 8'hE0) lo = 8'hA0;
            if (lead == 8'hED) hi = 8'h9F;
            if (lead == 8'hF0) lo = 8'h90;
            if (lead == 8'hF4) hi = 8'h8F;
            return b >= lo && b <= hi;
        endfunction

        function bit plain_ok(logic [7:0] b);
            return b == CH_TAB || b == CH_LF || b == CH_CR || (b >= 8'h20 && b <= 8'h7E);
        endfunction

        function ufhu_out_t word(logic [7:0] b);
            ufhu_out_t w;
            w.out_byte  = b;
            w.out_valid = 1'b1;
            w.out_last  = 1'b0;
            return w;
        endfunction

        function void note_escaped_byte(ufhu_in_t w);
            ufhu_out_t  res[5];
            int         n;
            logic [7:0] b;
            bit         done;
            bit         fits;
            n    = 0;
            b    = w.in_byte;
            done = 1'b0;

            if (seq_held != 0) begin
                fits = (seq_held == 1) ? second_ok(seq_buf[0], b) : (b[7:6] == 2'b10);
                if (fits) begin
                    done = 1'b1;
                    if (seq_held + 1 >= lead_len(seq_buf[0])) begin
                        for (int k = 0; k < seq_held; k++) begin
                            res[n] = word(seq_buf[k]);
                            n++;
                        end
                        res[n] = word(b);
                        n++;
                        seq_held = 0;
                    end else begin
                        seq_buf[seq_held] = b;
                        seq_held++;
                    end
                end else begin
                    // broken sequence: held bytes go, b starts over
                    seq_held = 0;
                end
            end

            if (!done && bslash_held) begin
                bslash_held = 1'b0;
                done = 1'b1;
                if (b == CH_LOW_R)       res[n] = word(CH_CR);
                else if (b == CH_LOW_N)  res[n] = word(CH_LF);
                else if (b == CH_LOW_C)  res[n] = word(CH_COLON);
                else if (b == CH_BSLASH) res[n] = word(CH_BSLASH);
                else begin
                    res[n] = word(CH_BSLASH);
                    done = 1'b0;
                end
                n++;
            end

            if (!done) begin
                if (b == CH_BSLASH) begin
                    bslash_held = 1'b1;
                end else if (plain_ok(b)) begin
                    res[n] = word(b);
                    n++;
                end else if (lead_len(b) != 0) begin
                    seq_buf[0] = b;
                    seq_held   = 1;
                end
            end

            if (w.in_last) begin
                if (bslash_held) begin
                    res[n] = word(CH_BSLASH);
                    n++;
                end
                bslash_held = 1'b0;
                seq_held    = 0;
                if (n == 0) begin
                    res[0] = '0;
                    n = 1;
                end
                res[n-1].out_last = 1'b1;
            end

            for (int k = 0; k < n; k++) decoded_q = {decoded_q, res[k]};
        endfunction

        function void check_decoded(ufhu_out_t got);
            ufhu_out_t want;
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                         got.out_byte);
                errors++;
            end
            if (got.out_valid !== want.out_valid) begin
                $display("%0t: out_valid expected %b actual %b", $time, want.out_valid,
                         got.out_valid);
                errors++;
            end
            if (got.out_last !== want.out_last) begin
                $display("%0t: out_last expected %b actual %b", $time, want.out_last,
                         got.out_last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return decoded_q.size();
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ufhu_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ufhu_out_t m_data;

    unescape_scoreboard sb;

    logic [7:0]  str_q[$];      // escaped string being sent
    int unsigned words_sent = 0;
    int unsigned tx_max     = 0; // sender gap bound, 0 = back to back
    int unsigned rx_max     = 0; // receiver stall bound, 0 = always ready
    int unsigned rx_hold    = 0; // one-shot long hold-off request
    int unsigned rx_wait    = 0;

    utf8_filtering_header_unescaper dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Offer one word after a random gap and hold it until taken. With no gap, valid
    // simply stays high so it is never lowered and raised in the same step.
    task automatic send_word(input ufhu_in_t w);
        int unsigned gap;
        gap = $urandom_range(0, tx_max);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_escaped_byte(w);
        words_sent++;
    endtask

    task automatic send_string();
        ufhu_in_t w;
        for (int i = 0; i < str_q.size(); i++) begin
            w.in_byte = str_q[i];
            w.in_last = (i == str_q.size() - 1);
            send_word(w);
        end
    endtask

    // Sender goes quiet until every predicted word has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Appends one byte to the string being built.
    function automatic void queue_byte(logic [7:0] b);
        str_q = {str_q, b};
    endfunction

    // Well-formed 2..4 byte sequence, or its head only when cut is set.
    function automatic void add_utf8(int unsigned len, bit cut);
        logic [7:0]  seq[4];
        logic [7:0]  lo;
        logic [7:0]  hi;
        int unsigned keep;
        case (len)
            2: seq[0] = 8'($urandom_range(8'hC2, 8'hDF));
            3: begin
                if ($urandom_range(0, 3) == 0) begin
                    seq[0] = ($urandom_range(0, 1) != 0) ? 8'hE0 : 8'hED;
                end else begin
                    seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
                end
            end
            default: begin
                if ($urandom_range(0, 3) == 0) begin
                    seq[0] = ($urandom_range(0, 1) != 0) ? 8'hF0 : 8'hF4;
                end else begin
                    seq[0] = 8'($urandom_range(8'hF0, 8'hF4));
                end
            end
        endcase
        lo = 8'h80;
        hi = 8'hBF;
        if (seq[0] == 8'hE0) lo = 8'hA0;
        if (seq[0] == 8'hED) hi = 8'h9F;
        if (seq[0] == 8'hF0) lo = 8'h90;
        if (seq[0] == 8'hF4) hi = 8'h8F;
        seq[1] = 8'($urandom_range(lo, hi));
        seq[2] = 8'($urandom_range(8'h80, 8'hBF));
        seq[3] = 8'($urandom_range(8'h80, 8'hBF));
        keep = cut ? $urandom_range(1, len - 1) : len;
        for (int k = 0; k < keep; k++) queue_byte(seq[k]);
    endfunction

    // Mostly well-formed text with escapes and UTF-8, salted with broken sequences,
    // stray backslashes and raw noise.
    function automatic void build_random_string();
        int unsigned ntok;
        int unsigned pick;
        str_q.delete();
        ntok = $urandom_range(1, 8);
        repeat (ntok) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                queue_byte(8'($urandom_range(8'h20, 8'h7E)));
            end else if (pick < 43) begin
                queue_byte(CH_BSLASH);
                case ($urandom_range(0, 4))
                    0: queue_byte(CH_LOW_R);
                    1: queue_byte(CH_LOW_N);
                    2: queue_byte(CH_LOW_C);
                    3: queue_byte(CH_BSLASH);
                    default: queue_byte(8'($urandom_range(8'h20, 8'h7E)));
                endcase
            end else if (pick < 48) begin
                queue_byte(CH_BSLASH);
            end else if (pick < 75) begin
                add_utf8($urandom_range(2, 4), 1'b0);
            end else if (pick < 85) begin
                add_utf8($urandom_range(2, 4), 1'b1);
            end else begin
                queue_byte(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    task automatic run_random(input int unsigned until_words);
        while (words_sent < until_words) begin
            build_random_string();
            send_string();
        end
    endtask

    // Result side: one decision per cycle. A stall is drawn after every accepted word,
    // and a long hold-off request overrides it.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_decoded(m_data);
                rx_wait = $urandom_range(0, rx_max);
            end
            if (rx_hold != 0) begin
                rx_wait = rx_hold;
                rx_hold = 0;
            end
            if (rx_wait != 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: every escape, a backslash before an ordinary byte, control bytes
        // that pass or drop, and a string ending on a held backslash.
        tx_max = 3;
        rx_max = 3;
        str_q = '{CH_BSLASH, CH_LOW_R, CH_BSLASH, CH_LOW_N, CH_BSLASH, CH_LOW_C,
                  CH_BSLASH, CH_BSLASH, CH_BSLASH, 8'h71, CH_TAB, 8'h00, 8'h7F, 8'h7E,
                  CH_BSLASH};
        send_string();
        // Largest code point, overlong and surrogate starts, a bad lead, and a lead cut
        // off by the end of the string (bare end marker).
        str_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hE0, 8'h80, 8'hED, 8'hA0, 8'hFF, 8'hC3};
        send_string();
        wait_drained();

        // Random traffic with gaps on both sides.
        tx_max = 14;
        rx_max = 14;
        run_random(words_sent + 40);
        wait_drained();

        // Receiver holds off while the sender streams back to back: the queue fills
        // and s_ready must drop.
        rx_max  = 0;
        tx_max  = 0;
        rx_hold = 60;
        run_random(words_sent + 20);

        // No idling on either side.
        run_random(words_sent + 20);

        // Sender gaps only, then both sides again.
        tx_max = 14;
        run_random(words_sent + 15);
        rx_max = 14;
        run_random(words_sent + 15);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("utf8_filtering_header_unescaper_tb: clean");
        end else begin
            $display("utf8_filtering_header_unescaper_tb: errors");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("utf8_filtering_header_unescaper_tb: errors");
        $finish;
    end

endmodule
